// ===== src/ram_mixer_pkg.sv =====
package ram_mixer_pkg;
    localparam int NUM_VOICES = 4;
    localparam int VOICE_FRAMES = 4096;
    localparam int MAX_CHANNELS = 2;
    localparam int VOICE_BITS = 2;
    localparam int FRAME_BITS = 12;
    localparam int STORE_DEPTH = NUM_VOICES * VOICE_FRAMES * MAX_CHANNELS;
    localparam int ADDR_BITS = $clog2(STORE_DEPTH);
    localparam int PH_BITS = 25;
    localparam int LEN_BITS = 13;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_MIX = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [2:0] REG_CHANNELS = 3'd0;

    typedef struct packed {
        logic clear_sums;
        logic load_voice;
        logic issue_a;
        logic issue_b;
        logic take_a;
        logic take_b;
        logic multiply;
        logic accumulate;
        logic advance;
        logic [1:0] voice;
        logic chan;
    } dp_cmd_t;

    typedef struct packed {
        logic active;
    } dp_status_t;
endpackage

// ===== src/resampling_audio_mixer.sv =====
// Channel   Direction  Handshake          Payload
// s_axis    in         s_tvalid/s_tready  op, voice, frame, channel, sample
// m_axis    out        m_tvalid/m_tready  mixed_left, mixed_right
// cfg       in         cfg_valid/ready    register index, 46-bit value
// A mix word visits the four voices in turn: a silent voice passes load and check,
// a playing one adds read A, read B, take B, multiply, product and add per channel,
// and a finish state closes the word, a sequence set by the single store read port and the
// shared multiplier chain. Reset is synchronous and active low. The result waits
// in an output register while a stalled master side holds only the next mix word.
module resampling_audio_mixer
    import ram_mixer_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // op, voice_index, frame_address, channel_index, sample_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // mixed_left, mixed_right
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [45:0] cfg_data
);
    dp_cmd_t    cmd;
    dp_status_t status;
    logic       busy, done, stereo, acc, start;
    logic signed [15:0] ml, mr;
    logic [1:0] op;
    logic [31:0] out_reg;
    logic        out_valid_reg;

    assign op = s_tdata[1:0];
    assign s_tready = !busy && !(out_valid_reg && op == OP_MIX);
    assign acc = s_tvalid && s_tready;
    assign start = acc && op == OP_MIX;
    assign cfg_ready = 1'b1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_reg;

    ram_mixer_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .start(start), .stereo(stereo),
        .status(status), .cmd(cmd), .busy(busy), .done(done)
    );

    ram_mixer_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .cfg_we(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .load_we(acc && op == OP_LOAD), .load_voice(s_tdata[3:2]),
        .load_frame(s_tdata[15:4]), .load_chan(s_tdata[16]),
        .load_sample($signed(s_tdata[32:17])), .restart(acc && op == OP_RESTART),
        .stereo(stereo), .mix_left(ml), .mix_right(mr)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (done) begin
                out_valid_reg <= 1'b1;
                out_reg <= {mr, ml};
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end
endmodule

// ===== src/ram_mixer_ram.sv =====
module ram_mixer_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/ram_mixer_datapath.sv =====
module ram_mixer_datapath
    import ram_mixer_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dp_cmd_t                 cmd,
    output dp_status_t              status,
    input  logic                    cfg_we,
    input  logic [2:0]              cfg_index,
    input  logic [45:0]             cfg_data,
    input  logic                    load_we,
    input  logic [1:0]              load_voice,
    input  logic [11:0]             load_frame,
    input  logic                    load_chan,
    input  logic signed [15:0]      load_sample,
    input  logic                    restart,
    output logic                    stereo,
    output logic signed [15:0]      mix_left,
    output logic signed [15:0]      mix_right
);
    logic [1:0]          chan_count_reg;
    logic [45:0]         ctl_reg [NUM_VOICES];
    logic [PH_BITS-1:0]  ph_reg [NUM_VOICES];
    logic [15:0]         vol_reg;
    logic [15:0]         pitch_reg;
    logic [LEN_BITS-1:0] len_reg;
    logic [PH_BITS-1:0]  cur_ph_reg;
    logic                active_reg;
    logic signed [15:0]  a_reg, b_reg;
    logic signed [29:0]  interp_reg;
    logic signed [47:0]  prod_reg;
    logic signed [20:0]  sum_reg [2];
    logic [ADDR_BITS-1:0] raddr;
    logic [15:0]         rdata;
    logic [LEN_BITS-1:0] len_eff;
    logic [LEN_BITS-1:0] fa;
    logic [12:0]         t;
    logic                b_valid;
    logic [PH_BITS:0]    ph_sum;
    logic [PH_BITS:0]    limit;
    logic signed [47:0]  rounded;
    logic [LEN_BITS-1:0] frame_sel;

    ram_mixer_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_store (
        .aclk (aclk),
        .we   (load_we),
        .waddr({load_voice, load_frame, load_chan}),
        .wdata(load_sample),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb begin
        logic [45:0] c;
        c = ctl_reg[cmd.voice];
        len_eff = (c[45:33] > LEN_BITS'(VOICE_FRAMES)) ? LEN_BITS'(VOICE_FRAMES) : c[45:33];
    end

    assign fa = cur_ph_reg[PH_BITS-1:12];
    assign t = {1'b0, cur_ph_reg[11:0]};
    assign b_valid = (LEN_BITS'(fa + 1'b1) < len_reg) && (fa != {LEN_BITS{1'b1}});
    assign frame_sel = cmd.issue_b ? LEN_BITS'(fa + 1'b1) : fa;
    assign raddr = {cmd.voice, frame_sel[FRAME_BITS-1:0], cmd.chan};
    assign ph_sum = {1'b0, cur_ph_reg} + {{(PH_BITS-15){1'b0}}, pitch_reg};
    assign limit = {1'b0, len_reg, 12'd0};
    assign rounded = (prod_reg + 48'sd67108864) >>> 27;
    assign stereo = (chan_count_reg == 2'd2) && (MAX_CHANNELS >= 2);
    assign status.active = active_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_count_reg <= 2'd2;
            for (int i = 0; i < NUM_VOICES; i++) begin
                ctl_reg[i] <= '0;
                ph_reg[i] <= '0;
            end
            sum_reg[0] <= '0;
            sum_reg[1] <= '0;
            active_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_CHANNELS) begin
                    chan_count_reg <= cfg_data[1:0];
                end else if (cfg_index <= 3'(NUM_VOICES)) begin
                    ctl_reg[VOICE_BITS'(cfg_index - 3'd1)] <= cfg_data;
                end
            end
            if (restart) begin
                ph_reg[load_voice] <= '0;
            end
            if (cmd.clear_sums) begin
                sum_reg[0] <= '0;
                sum_reg[1] <= '0;
            end
            if (cmd.load_voice) begin
                vol_reg <= ctl_reg[cmd.voice][16:1];
                pitch_reg <= ctl_reg[cmd.voice][32:17];
                len_reg <= len_eff;
                cur_ph_reg <= ph_reg[cmd.voice];
                active_reg <= ctl_reg[cmd.voice][0] &&
                              (ph_reg[cmd.voice][PH_BITS-1:12] < len_eff);
            end
            if (cmd.take_a) begin
                a_reg <= $signed(rdata);
            end
            if (cmd.take_b) begin
                b_reg <= b_valid ? $signed(rdata) : 16'sd0;
            end
            if (cmd.multiply) begin
                interp_reg <= 30'(a_reg * $signed({1'b0, 13'd4096 - t}))
                            + 30'(b_reg * $signed({1'b0, t}));
            end
            if (cmd.accumulate) begin
                prod_reg <= interp_reg * $signed({1'b0, vol_reg});
            end
            if (cmd.advance) begin
                sum_reg[cmd.chan] <= sum_reg[cmd.chan] + 21'(rounded);
            end
            if (cmd.advance && cmd.issue_a) begin
                ph_reg[cmd.voice] <= (ph_sum > limit) ? PH_BITS'(limit) : PH_BITS'(ph_sum);
            end
        end
    end

    always_comb begin
        mix_left = (sum_reg[0] > 21'sd32767) ? 16'sd32767 :
                   (sum_reg[0] < -21'sd32768) ? -16'sd32768 : 16'(sum_reg[0]);
        mix_right = !stereo ? 16'sd0 :
                    (sum_reg[1] > 21'sd32767) ? 16'sd32767 :
                    (sum_reg[1] < -21'sd32768) ? -16'sd32768 : 16'(sum_reg[1]);
    end
endmodule

// ===== src/ram_mixer_ctrl.sv =====
module ram_mixer_ctrl
    import ram_mixer_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  logic       stereo,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       done
);
    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_CHECK, S_RDA, S_RDB, S_TAKEB, S_MUL, S_PROD, S_ADD, S_FINISH
    } state_t;

    state_t state_reg;
    logic [1:0] voice_reg;
    logic       chan_reg;

    assign busy = (state_reg != S_IDLE);

    always_comb begin
        cmd = '0;
        cmd.voice = voice_reg;
        cmd.chan = chan_reg;
        done = 1'b0;
        case (state_reg)
            S_IDLE:   cmd.clear_sums = start;
            S_LOAD:   cmd.load_voice = 1'b1;
            S_RDA:    cmd.issue_a = 1'b1;
            S_RDB:    begin cmd.issue_b = 1'b1; cmd.take_a = 1'b1; end
            S_TAKEB:  cmd.take_b = 1'b1;
            S_MUL:    cmd.multiply = 1'b1;
            S_PROD:   cmd.accumulate = 1'b1;
            S_ADD:    begin
                cmd.advance = 1'b1;
                cmd.issue_a = (chan_reg == 1'b1) || !stereo;
            end
            S_FINISH: done = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            voice_reg <= '0;
            chan_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: if (start) begin
                    voice_reg <= '0;
                    chan_reg <= 1'b0;
                    state_reg <= S_LOAD;
                end
                S_LOAD:  state_reg <= S_CHECK;
                S_CHECK: begin
                    chan_reg <= 1'b0;
                    if (status.active) begin
                        state_reg <= S_RDA;
                    end else if (voice_reg == 2'(NUM_VOICES - 1)) begin
                        state_reg <= S_FINISH;
                    end else begin
                        voice_reg <= voice_reg + 2'd1;
                        state_reg <= S_LOAD;
                    end
                end
                S_RDA:   state_reg <= S_RDB;
                S_RDB:   state_reg <= S_TAKEB;
                S_TAKEB: state_reg <= S_MUL;
                S_MUL:   state_reg <= S_PROD;
                S_PROD:  state_reg <= S_ADD;
                S_ADD: begin
                    if (stereo && chan_reg == 1'b0) begin
                        chan_reg <= 1'b1;
                        state_reg <= S_RDA;
                    end else if (voice_reg == 2'(NUM_VOICES - 1)) begin
                        state_reg <= S_FINISH;
                    end else begin
                        voice_reg <= voice_reg + 2'd1;
                        state_reg <= S_LOAD;
                    end
                end
                S_FINISH: state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== dv/tb.sv =====
module tb;
    import ram_mixer_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic [2:0] REG_VOICE0 = 3'd1;
    localparam logic [2:0] REG_UNUSED = 3'd5;
    localparam int SETTLE_CYCLES = 120;

    typedef struct packed {
        logic signed [15:0] right;
        logic signed [15:0] left;
    } mix_frame_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [45:0] cfg_data = '0;

    logic signed [15:0] sample_mem [STORE_DEPTH];
    bit                 sample_written [STORE_DEPTH];
    logic [PH_BITS-1:0] playhead [NUM_VOICES];
    logic [45:0]        voice_ctl [NUM_VOICES];
    logic [1:0]         chan_cnt;

    mix_frame_t pending_mixes [$];
    int  err_count = 0;
    bit  no_idle = 1'b0;
    bit  hold_start = 1'b0;
    int  hold_left = 0;

    resampling_audio_mixer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(8 * 2_000_000);
        $display("FAILURE");
        $finish;
    end

    function automatic int store_idx(int v, int f, int c);
        return (v * VOICE_FRAMES + f) * MAX_CHANNELS + c;
    endfunction

    function automatic longint eff_len(logic [45:0] ctl);
        longint len;
        len = ctl[45:33];
        return (len > VOICE_FRAMES) ? VOICE_FRAMES : len;
    endfunction

    function automatic void predict_mix(output mix_frame_t res);
        longint sum [2];
        longint len, fa, t, a, b, interp, ph, vol, limit;
        int chans;
        sum[0] = 0;
        sum[1] = 0;
        chans = (chan_cnt == 2'd2) ? 2 : 1;
        for (int v = 0; v < NUM_VOICES; v++) begin
            if (!voice_ctl[v][0]) continue;
            len = eff_len(voice_ctl[v]);
            ph = playhead[v];
            fa = ph >> 12;
            if (fa >= len) continue;
            t = ph & 4095;
            vol = voice_ctl[v][16:1];
            for (int c = 0; c < chans; c++) begin
                a = sample_mem[store_idx(v, int'(fa), c)];
                b = (fa + 1 < len) ? longint'(sample_mem[store_idx(v, int'(fa + 1), c)]) : 0;
                interp = a * (4096 - t) + b * t;
                sum[c] += (interp * vol + (longint'(1) << 26)) >>> 27;
            end
            limit = len << 12;
            ph += voice_ctl[v][32:17];
            if (ph > limit) ph = limit;
            playhead[v] = ph[PH_BITS-1:0];
        end
        for (int c = 0; c < 2; c++) begin
            if (sum[c] > 32767) sum[c] = 32767;
            if (sum[c] < -32768) sum[c] = -32768;
        end
        res.left = sum[0][15:0];
        res.right = (chans == 2) ? sum[1][15:0] : 16'sd0;
    endfunction

    task automatic send_word(logic [1:0] op, int voice, int frame, int chan, int sample);
        mix_frame_t res;
        int vi, fi, ci;
        vi = voice & 3;
        fi = frame & 4095;
        ci = chan & 1;
        if (!no_idle && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, 16'(sample), 1'(ci), 12'(fi), 2'(vi), op};
        do @(posedge aclk); while (!s_tready);
        case (op)
            OP_LOAD: begin
                sample_mem[store_idx(vi, fi, ci)] = 16'(sample);
                sample_written[store_idx(vi, fi, ci)] = 1'b1;
            end
            OP_RESTART: playhead[vi] = '0;
            OP_MIX: begin
                predict_mix(res);
                pending_mixes = {pending_mixes, res};
            end
            default: ;
        endcase
    endtask

    // Any frame the next mix will read gets loaded first, so no unwritten entry feeds the mix.
    task automatic send_mix();
        longint len, fa;
        for (int v = 0; v < NUM_VOICES; v++) begin
            if (!voice_ctl[v][0]) continue;
            len = eff_len(voice_ctl[v]);
            fa = playhead[v] >> 12;
            if (fa >= len) continue;
            for (int f = int'(fa); f <= fa + 1 && f < len; f++)
                for (int c = 0; c < MAX_CHANNELS; c++)
                    if (!sample_written[store_idx(v, f, c)])
                        send_word(OP_LOAD, v, f, c, $urandom);
        end
        send_word(OP_MIX, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_mixes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(int idx, logic [45:0] value);
        s_tvalid <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= 3'(idx);
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_CHANNELS)
            chan_cnt = value[1:0];
        else if (idx >= REG_VOICE0 && idx < REG_VOICE0 + NUM_VOICES)
            voice_ctl[idx - REG_VOICE0] = value;
        @(posedge aclk);
    endtask

    function automatic logic [45:0] voice_word(bit play, logic [15:0] vol, logic [15:0] pitch,
                                               logic [12:0] len);
        return {len, pitch, vol, play};
    endfunction

    function automatic logic [45:0] random_voice();
        logic [15:0] vol, pitch;
        logic [12:0] len;
        case ($urandom_range(3))
            0: vol = 16'h8000;
            1: vol = 16'hFFFF;
            default: vol = 16'($urandom);
        endcase
        case ($urandom_range(5))
            0: pitch = 16'hFFFF;
            1: pitch = 16'h0000;
            default: pitch = 16'($urandom_range(16'h3000));
        endcase
        case ($urandom_range(9))
            0: len = 13'd0;
            1: len = 13'd8191;
            2: len = 13'd4096;
            3: len = 13'($urandom);
            default: len = 13'($urandom_range(1, 48));
        endcase
        return voice_word($urandom_range(99) < 80, vol, pitch, len);
    endfunction

    task automatic random_config();
        write_reg(REG_CHANNELS, 46'($urandom_range(3)));
        for (int v = 0; v < NUM_VOICES; v++)
            write_reg(REG_VOICE0 + v, random_voice());
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(REG_UNUSED, 7), 46'({$urandom, $urandom}));
    endtask

    task automatic random_words(int count);
        int roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if (roll < 55)
                send_mix();
            else if (roll < 80)
                send_word(OP_LOAD, $urandom, ($urandom_range(9) < 7) ? $urandom_range(63)
                          : $urandom, $urandom, $urandom);
            else if (roll < 95)
                send_word(OP_RESTART, $urandom, $urandom, $urandom, $urandom);
            else
                send_word(OP_NONE, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic test_directed();
        logic [15:0] extremes [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
        for (int f = 0; f < 4; f++) begin
            send_word(OP_LOAD, 0, f, 0, extremes[f]);
            send_word(OP_LOAD, 0, f, 1, extremes[3 - f]);
        end
        wait_drained();
        write_reg(REG_VOICE0, voice_word(1, 16'h8000, 16'h0800, 13'd3));
        for (int i = 0; i < 8; i++) send_mix();
        send_word(OP_RESTART, 0, 0, 0, 0);
        send_word(OP_NONE, 3, 12'hFFF, 1, 16'hFFFF);
        send_mix();
        wait_drained();
        // Every voice plays at full volume and full pitch on the loaded samples, so the sums can reach the clamp.
        for (int v = 0; v < NUM_VOICES; v++) begin
            write_reg(REG_VOICE0 + v, voice_word(1, 16'hFFFF, 16'hFFFF, 13'd8191));
            send_word(OP_RESTART, v, 0, 0, 0);
        end
        for (int i = 0; i < 3; i++) send_mix();
        wait_drained();
        write_reg(REG_CHANNELS, 46'd1);
        send_mix();
        wait_drained();
        write_reg(REG_CHANNELS, 46'd0);
        send_mix();
        wait_drained();
        write_reg(REG_CHANNELS, 46'd3);
        write_reg(7, '1);
        send_mix();
        wait_drained();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 6; phase++) begin
            no_idle = (phase == 3);
            random_config();
            for (int v = 0; v < NUM_VOICES; v++)
                send_word(OP_RESTART, v, $urandom, $urandom, $urandom);
            random_words(100);
            wait_drained();
        end
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        write_reg(REG_CHANNELS, 46'd2);
        for (int v = 0; v < NUM_VOICES; v++) begin
            write_reg(REG_VOICE0 + v, voice_word(1, 16'($urandom),
                                                  16'($urandom_range(16'h0400)), 13'd40));
            send_word(OP_RESTART, v, 0, 0, 0);
        end
        hold_start <= 1'b1;
        for (int i = 0; i < 30; i++) send_mix();
        wait_drained();
        random_words(100);
        wait_drained();
    endtask

    always @(posedge aclk) begin
        if (hold_start) begin
            hold_start <= 1'b0;
            hold_left <= 600;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (no_idle) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 20);
        end
    end

    always @(posedge aclk) begin
        mix_frame_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_mixes.size() == 0) begin
                $error("unexpected word: mixed_left %0d mixed_right %0d", got.left, got.right);
                err_count++;
            end else begin
                want = pending_mixes.pop_front();
                if (got.left !== want.left) begin
                    $error("mixed_left expected %0d actual %0d", want.left, got.left);
                    err_count++;
                end
                if (got.right !== want.right) begin
                    $error("mixed_right expected %0d actual %0d", want.right, got.right);
                    err_count++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            sample_mem[i] = '0;
            sample_written[i] = 1'b0;
        end
        for (int v = 0; v < NUM_VOICES; v++) begin
            playhead[v] = '0;
            voice_ctl[v] = '0;
        end
        chan_cnt = 2'd2;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        test_directed();
        test_random();
        test_backpressure();
        wait_drained();
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ===== resampling_audio_mixer.f =====
src/ram_mixer_pkg.sv
src/ram_mixer_ram.sv
src/ram_mixer_datapath.sv
src/ram_mixer_ctrl.sv
src/resampling_audio_mixer.sv
dv/tb.sv
